// ===== design/mtpc_pkg.sv =====
// Package for the memory test pattern checker unit.
// Holds the item types, mode/action/register codes and the pattern helpers.
// Depends on nothing; every other design file imports it.
package mtpc_pkg;

   // Word index width; indexes are taken modulo 2**INDEX_BITS
   localparam int INDEX_BITS = 32;
   localparam logic [31:0] IndexMask = 32'((64'd1 << INDEX_BITS) - 64'd1);

   // Read-modify-write and increment constant
   localparam logic [31:0] KConst = 32'h1638_3245;
   localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;
   localparam logic [31:0] CheckerEven = 32'h5555_5555;
   localparam logic [31:0] CheckerOdd = 32'hAAAA_AAAA;
   localparam logic [31:0] LowHalfOnes = 32'h0000_FFFF;
   // Largest quotient of a 32-bit word by KConst
   localparam int DivSteps = 11;

   // Test modes
   localparam logic [4:0] MODE_SOLID = 5'd0;
   localparam logic [4:0] MODE_CHECKER = 5'd1;
   localparam logic [4:0] MODE_BLOCK_SEQ = 5'd2;
   localparam logic [4:0] MODE_WALK = 5'd3;
   localparam logic [4:0] MODE_BIT_SPREAD = 5'd4;
   localparam logic [4:0] MODE_BIT_FLIP = 5'd5;
   localparam logic [4:0] MODE_SEQ_INC = 5'd6;
   localparam logic [4:0] MODE_CONSTANT = 5'd7;
   localparam logic [4:0] MODE_ADDRESS = 5'd8;
   localparam logic [4:0] MODE_ADDR5_FULL = 5'd9;
   localparam logic [4:0] MODE_ADDR5_HALF = 5'd10;
   localparam logic [4:0] MODE_RMW_XOR = 5'd11;
   localparam logic [4:0] MODE_RMW_SUB = 5'd12;
   localparam logic [4:0] MODE_RMW_MUL = 5'd13;
   localparam logic [4:0] MODE_RMW_DIV = 5'd14;
   localparam logic [4:0] MODE_RMW_OR = 5'd15;
   localparam logic [4:0] MODE_RMW_AND = 5'd16;

   // Actions
   localparam logic [1:0] ACT_GENERATE = 2'd0;
   localparam logic [1:0] ACT_CHECK = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   // Configuration register indexes
   localparam logic CSR_TEST_MODE = 1'b0;
   localparam logic CSR_WALK_INV = 1'b1;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  pass_index;
      logic [31:0] word_index;
      logic [31:0] word_address;
      logic [31:0] read_a;
      logic [31:0] read_b;
   } req_type;

   typedef struct packed {
      logic [31:0] write_a;
      logic [31:0] write_b;
      logic        mismatch;
      logic        error_seen;
      logic [31:0] first_fail_index;
   } rsp_type;

   typedef struct packed {
      logic [4:0] test_mode;
      logic       walk_inverted;
   } cfg_type;

   typedef struct packed {
      logic [31:0] write_a;
      logic [31:0] write_b;
      logic        single;
   } pattern_type;

   // One-hot word for a bit position; out-of-range positions give zero
   function automatic logic [31:0] bit_at(input logic signed [9:0] pos);
      logic [31:0] word;
      word = '0;
      if (pos >= 10'sd0 && pos < 10'sd32) begin
         word = 32'd1 << pos[4:0];
      end
      return word;
   endfunction

   // Complement the word on odd indexes
   function automatic logic [31:0] alternate(input logic [31:0] q, input logic odd);
      return odd ? ~q : q;
   endfunction

   // Quotient by KConst: count the multiples of KConst at or below the word
   function automatic logic [31:0] div_by_k(input logic [31:0] x);
      logic [3:0] q;
      q = '0;
      for (int n = 1; n <= DivSteps; n++) begin
         if ({32'd0, x} >= 64'(n) * 64'(KConst)) begin
            q = 4'(n);
         end
      end
      return {28'd0, q};
   endfunction

endpackage

// ===== design/mtpc_pattern.sv =====
// Pattern generator of the memory test pattern checker unit.
// Builds the words for both regions from the mode and one item; pure logic.
// Depends on mtpc_pkg.
module mtpc_pattern import mtpc_pkg::*; (
   input  cfg_type     cfg,
   input  req_type     item,
   output pattern_type pat
);

   logic [31:0]       idx;
   logic [7:0]        j;
   logic signed [9:0] sj;
   logic [31:0]       q;
   logic [31:0]       wa;
   logic [31:0]       wb;
   logic              rmw;
   logic              single;

   assign idx = item.word_index & IndexMask;
   assign j   = item.pass_index;
   assign sj  = signed'({2'b00, j});

   // Select the pattern word, or the read-modify-write results
   always_comb begin
      q      = '0;
      wa     = '0;
      wb     = '0;
      rmw    = 1'b0;
      single = 1'b0;
      unique case (cfg.test_mode)
         MODE_SOLID: begin
            q = alternate(j[0] ? 32'd0 : AllOnes, idx[0]);
         end
         MODE_CHECKER: begin
            q = alternate(j[0] ? CheckerOdd : CheckerEven, idx[0]);
         end
         MODE_BLOCK_SEQ: begin
            q = {24'd0, j};
         end
         MODE_WALK: begin
            q = (j < 8'd32) ? bit_at(sj) : bit_at(10'sd63 - sj);
            if (cfg.walk_inverted) begin
               q = ~q;
            end
         end
         MODE_BIT_SPREAD: begin
            q = (j < 8'd32) ? (bit_at(sj) | bit_at(sj + 10'sd2))
                            : (bit_at(10'sd63 - sj) | bit_at(10'sd65 - sj));
            q = alternate(q, idx[0]);
         end
         MODE_BIT_FLIP: begin
            q = bit_at(signed'({5'd0, j[7:3]}));
            q = alternate(j[0] ? q : ~q, idx[0]);
         end
         MODE_SEQ_INC: begin
            q = idx + KConst;
         end
         MODE_CONSTANT: begin
            q = KConst;
         end
         MODE_ADDRESS: begin
            q      = (idx[0] ^ j[0]) ? ~item.word_address : item.word_address;
            single = 1'b1;
         end
         MODE_ADDR5_FULL: begin
            q      = item.word_address[5] ? AllOnes : 32'd0;
            single = 1'b1;
         end
         MODE_ADDR5_HALF: begin
            q      = item.word_address[5] ? LowHalfOnes : 32'd0;
            single = 1'b1;
         end
         MODE_RMW_XOR: begin
            wa  = item.read_a ^ KConst;
            wb  = item.read_b ^ KConst;
            rmw = 1'b1;
         end
         MODE_RMW_SUB: begin
            wa  = item.read_a - KConst;
            wb  = item.read_b - KConst;
            rmw = 1'b1;
         end
         MODE_RMW_MUL: begin
            wa  = item.read_a * KConst;
            wb  = item.read_b * KConst;
            rmw = 1'b1;
         end
         MODE_RMW_DIV: begin
            wa  = div_by_k(item.read_a);
            wb  = div_by_k(item.read_b);
            rmw = 1'b1;
         end
         MODE_RMW_OR: begin
            wa  = item.read_a | KConst;
            wb  = item.read_b | KConst;
            rmw = 1'b1;
         end
         MODE_RMW_AND: begin
            wa  = item.read_a & KConst;
            wb  = item.read_b & KConst;
            rmw = 1'b1;
         end
         default: begin
            q = '0;
         end
      endcase
   end

   // Pattern modes drive A with the pattern and B with it unless single-region
   always_comb begin
      pat.single  = single;
      pat.write_a = rmw ? wa : q;
      pat.write_b = rmw ? wb : (single ? 32'd0 : q);
   end

endmodule

// ===== design/memory_test_pattern_checker_unit.sv =====
// Memory test pattern checker unit: top level.
// Input register, pattern/check logic, result register and error state.
// Depends on mtpc_pkg and mtpc_pattern.

// The unit takes one item per clock while results are taken, and returns one
// result item per item, in order. An accepted item is held in the input
// register and its result is then registered in the result register; the
// sustained rate is one item per cycle while results are taken, with a
// single pass of pattern, multiply/divide-by-constant and compare logic
// between the two registers. While a result waits to be taken, the input
// register still takes one more item and then holds off. The sticky error
// flag and the first failing word index are updated in item order as
// results are formed. Configuration writes take effect at once and are meant
// to be made while no item is in flight.
module memory_test_pattern_checker_unit import mtpc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_wr_en,
   input  logic    csr_index,
   input  logic [4:0] csr_wdata
);

   cfg_type     cfg_ff, cfg_in;
   logic        s1_valid_ff, s1_valid_in;
   req_type     s1_data_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic        error_flag_ff, error_flag_in;
   logic [31:0] first_failure_ff, first_failure_in;
   logic        out_advance;
   logic        s1_fire;
   logic        bad;
   pattern_type pat;

   // Stage handshake: result register frees up, input register follows
   assign out_advance = !rsp_valid_ff || rsp_ready;
   assign req_ready   = !s1_valid_ff || out_advance;
   assign s1_fire     = s1_valid_ff && out_advance;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TEST_MODE: cfg_in.test_mode     = csr_wdata;
            CSR_WALK_INV:  cfg_in.walk_inverted = csr_wdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   mtpc_pattern u_pattern (
      .cfg  (cfg_ff),
      .item (s1_data_ff),
      .pat  (pat)
   );

   // Check, update the error state and form the result item
   always_comb begin
      bad              = 1'b0;
      error_flag_in    = error_flag_ff;
      first_failure_in = first_failure_ff;
      rsp_data_in      = '0;
      unique case (s1_data_ff.action)
         ACT_GENERATE: begin
            rsp_data_in.write_a = pat.write_a;
            rsp_data_in.write_b = pat.write_b;
         end
         ACT_CHECK: begin
            rsp_data_in.write_a = pat.write_a;
            rsp_data_in.write_b = pat.write_b;
            bad = pat.single ? (s1_data_ff.read_a != pat.write_a)
                             : (s1_data_ff.read_a != s1_data_ff.read_b);
            if (bad && !error_flag_ff) begin
               error_flag_in    = 1'b1;
               first_failure_in = s1_data_ff.word_index & IndexMask;
            end
         end
         ACT_CLEAR: begin
            error_flag_in    = 1'b0;
            first_failure_in = '0;
         end
         default: begin
            error_flag_in = error_flag_ff;
         end
      endcase
      rsp_data_in.mismatch         = bad;
      rsp_data_in.error_seen       = error_flag_in;
      rsp_data_in.first_fail_index = first_failure_in;
   end

   assign s1_valid_in  = req_ready ? req_valid : s1_valid_ff;
   assign rsp_valid_in = out_advance ? s1_valid_ff : rsp_valid_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff           <= '0;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         error_flag_ff    <= 1'b0;
         first_failure_ff <= '0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            error_flag_ff    <= error_flag_in;
            first_failure_ff <= first_failure_in;
         end
      end
   end

   // Payload registers: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
      if (s1_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== design/mtpc_checker.sv =====
// Port-level assertions for the memory test pattern checker unit.
// Depends on mtpc_pkg; bound to memory_test_pattern_checker_unit below.
module mtpc_checker import mtpc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // A failing word always leaves the sticky flag set
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.mismatch |-> rsp_data.error_seen)
      else $error("mismatch reported without error flag");

   // No failure recorded means no failing index
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.error_seen |-> rsp_data.first_fail_index == 32'd0)
      else $error("failing index set while error flag clear");

   // Reset empties the result register
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind memory_test_pattern_checker_unit mtpc_checker u_mtpc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
